FILE: src/brake_light_decider_unit_macros.svh
// ----------------------------------------------------------------------------
// Brake light decider assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef BRAKE_LIGHT_DECIDER_UNIT_MACROS_SVH
`define BRAKE_LIGHT_DECIDER_UNIT_MACROS_SVH

// same-cycle implication
`define BLD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brake light decider check failed");

// next-cycle implication
`define BLD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brake light decider check failed");

`endif

FILE: src/bld_pkg.sv
// ----------------------------------------------------------------------------
// Brake light decider package
// Types, register codes and fixed-point constants shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package bld_pkg;

   localparam int LED_COUNT_DEF = 16;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_START   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIGHT   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT = 2'd3;

   localparam logic [14:0] START_RST   = 15'd51;
   localparam logic [14:0] HOLD_RST    = 15'd77;
   localparam logic [11:0] LIGHT_RST   = 12'd150;
   localparam logic [15:0] TIMEOUT_RST = 16'd65000;

   localparam int REQ_W = 32;

   // averages are Q8 of 1/256 m/s^2, bounded to 24 bits signed
   localparam int AVG_W  = 24;
   localparam int DEC_W  = 25;
   localparam int MUL_W  = 29;
   localparam int PROD_W = 2 * MUL_W;

   // floor(2^32/11), floor(2^32/100)
   localparam logic [MUL_W-1:0] RECIP11  = 29'd390451572;
   localparam logic [MUL_W-1:0] RECIP100 = 29'd42949672;
   // 11*2^24 + 5 keeps the first numerator positive and rounds
   localparam logic signed [29:0] OFS11  = 30'sd184549381;
   // 100*2^18 + 50
   localparam logic signed [26:0] OFS100 = 27'sd26214450;
   localparam logic [26:0] BIAS11  = 27'd16777216;
   localparam logic [25:0] BIAS100 = 26'd262144;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_BRAKING = 2'd1,
      MODE_TIMEOUT = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_OFF  = 2'd1,
      ACT_TAIL = 2'd2,
      ACT_BAR  = 2'd3
   } led_action_type;

   typedef enum logic [3:0] {
      ST_WAIT,
      ST_TICK,
      ST_N1,
      ST_MUL1,
      ST_C1,
      ST_N2,
      ST_MUL2,
      ST_C2,
      ST_DEC,
      ST_MUL3,
      ST_C3,
      ST_OUT
   } ctl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_TICK,
      OP_N1,
      OP_MUL1,
      OP_C1,
      OP_N2,
      OP_MUL2,
      OP_C2,
      OP_DEC,
      OP_MUL3,
      OP_C3,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      logic      load_in;
      dp_op_type op;
   } dp_cmd_type;

endpackage

`default_nettype wire

FILE: src/bld_datapath.sv
// ----------------------------------------------------------------------------
// Brake light decider datapath
// Filter state, shared multiplier, reciprocal divides, mode and hold timer.
// ----------------------------------------------------------------------------
`default_nettype none

module bld_datapath #(
   parameter int LED_COUNT = bld_pkg::LED_COUNT_DEF,
   localparam int BAR_W = $clog2(LED_COUNT)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bld_pkg::dp_cmd_type           cmd,
   input  wire logic [27:0]                   in_data,
   input  wire logic                          csr_wen,
   input  wire logic [bld_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [bld_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic [1:0]                         out_action,
   output logic [BAR_W-1:0]                   out_bar,
   output logic                               out_braking
);

   localparam int BAR_OFS   = LED_COUNT * ((1022 + LED_COUNT - 1) / LED_COUNT);
   localparam int BAR_RECIP = (1 << 16) / LED_COUNT;

   logic signed [15:0] accel_ff, accel_in;
   logic [11:0] light_ff, light_in;
   logic [14:0] start_ff, start_in, hold_thr_ff, hold_thr_in;
   logic [11:0] light_thr_ff, light_thr_in;
   logic [15:0] timeout_ff, timeout_in;

   logic signed [bld_pkg::AVG_W-1:0] short_ff, short_in, long_ff, long_in;
   bld_pkg::mode_type mode_ff, mode_in;
   logic [15:0] hold_ff, hold_in;

   logic [bld_pkg::MUL_W-1:0]  num_ff, num_in;
   logic [bld_pkg::PROD_W-1:0] prod_ff, prod_in;
   bld_pkg::led_action_type act_ff, act_in;
   logic [BAR_W-1:0] bar_ff, bar_in;

   logic [1:0]       rsp_action_ff, rsp_action_in;
   logic [BAR_W-1:0] rsp_bar_ff, rsp_bar_in;
   logic             rsp_braking_ff, rsp_braking_in;

   logic [bld_pkg::MUL_W-1:0] mul_b;
   logic signed [29:0] n1;
   logic [25:0] q0;
   logic [29:0] rem1, rem2;
   logic [26:0] q1, s_new;
   logic [25:0] q2;
   logic signed [26:0] n2;
   logic signed [25:0] l_new;
   logic signed [bld_pkg::DEC_W-1:0] dec, start_lvl, hold_lvl, s_bias;
   logic signed [11:0] trunc_q;
   logic signed [12:0] bar_u;
   logic [11:0] q3, rem3, bar_r;
   logic [15:0] hold_inc;

   always_comb begin
      case (cmd.op)
         bld_pkg::OP_MUL1: mul_b = bld_pkg::RECIP11;
         bld_pkg::OP_MUL2: mul_b = bld_pkg::RECIP100;
         default:          mul_b = bld_pkg::MUL_W'(BAR_RECIP);
      endcase
   end

   always_comb begin
      n1 = 30'(short_ff) * 30'sd10 + {{6{accel_ff[15]}}, accel_ff, 8'h00} + bld_pkg::OFS11;
      q0 = prod_ff[57:32];
      rem1 = 30'(num_ff) - 30'(q0) * 30'd11;
      q1 = 27'(q0) + ((rem1 >= 30'd11) ? 27'd1 : 27'd0);
      s_new = q1 - bld_pkg::BIAS11;
      n2 = 27'(short_ff) - 27'(long_ff) + bld_pkg::OFS100;
      rem2 = 30'(num_ff) - 30'(q0) * 30'd100;
      q2 = q0 + ((rem2 >= 30'd100) ? 26'd1 : 26'd0);
      l_new = 26'(long_ff) + $signed(q2) - $signed(bld_pkg::BIAS100);
      dec = 25'(short_ff) - 25'(long_ff);
      start_lvl = $signed({2'b00, start_ff, 8'h00});
      hold_lvl = $signed({2'b00, hold_thr_ff, 8'h00});
      // truncate toward zero
      s_bias = 25'(short_ff) + (short_ff[bld_pkg::AVG_W-1] ? 25'sd8191 : 25'sd0);
      trunc_q = s_bias[24:13];
      bar_u = 13'(trunc_q) + 13'(2 + BAR_OFS);
      q3 = prod_ff[27:16];
      rem3 = num_ff[11:0] - 12'(q3 * 12'(LED_COUNT));
      bar_r = (rem3 >= 12'(LED_COUNT)) ? rem3 - 12'(LED_COUNT) : rem3;
      hold_inc = hold_ff + 16'd1;
   end

   always_comb begin
      accel_in = accel_ff;
      light_in = light_ff;
      start_in = start_ff;
      hold_thr_in = hold_thr_ff;
      light_thr_in = light_thr_ff;
      timeout_in = timeout_ff;
      short_in = short_ff;
      long_in = long_ff;
      mode_in = mode_ff;
      hold_in = hold_ff;
      num_in = num_ff;
      prod_in = prod_ff;
      act_in = act_ff;
      bar_in = bar_ff;
      rsp_action_in = rsp_action_ff;
      rsp_bar_in = rsp_bar_ff;
      rsp_braking_in = rsp_braking_ff;

      if (csr_wen) begin
         case (csr_addr)
            bld_pkg::CSR_START:   start_in = csr_wdata[14:0];
            bld_pkg::CSR_HOLD:    hold_thr_in = csr_wdata[14:0];
            bld_pkg::CSR_LIGHT:   light_thr_in = csr_wdata[11:0];
            bld_pkg::CSR_TIMEOUT: timeout_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.load_in) begin
         accel_in = $signed(in_data[15:0]);
         light_in = in_data[27:16];
      end

      case (cmd.op)
         bld_pkg::OP_TICK: begin
            act_in = bld_pkg::ACT_NONE;
            bar_in = '0;
            if (mode_ff == bld_pkg::MODE_BRAKING) begin
               if (hold_inc >= timeout_ff) begin
                  hold_in = '0;
                  mode_in = bld_pkg::MODE_TIMEOUT;
               end else begin
                  hold_in = hold_inc;
               end
            end
         end
         bld_pkg::OP_N1: num_in = n1[28:0];
         bld_pkg::OP_MUL1, bld_pkg::OP_MUL2, bld_pkg::OP_MUL3: begin
            prod_in = bld_pkg::PROD_W'(num_ff) * bld_pkg::PROD_W'(mul_b);
         end
         bld_pkg::OP_C1: short_in = s_new[bld_pkg::AVG_W-1:0];
         bld_pkg::OP_N2: num_in = 29'(n2[25:0]);
         bld_pkg::OP_C2: long_in = l_new[bld_pkg::AVG_W-1:0];
         bld_pkg::OP_DEC: begin
            num_in = 29'(bar_u[11:0]);
            act_in = bld_pkg::ACT_NONE;
            case (mode_ff)
               bld_pkg::MODE_BRAKING, bld_pkg::MODE_TIMEOUT: ;
               default: begin
                  act_in = (light_ff < light_thr_ff) ? bld_pkg::ACT_TAIL : bld_pkg::ACT_OFF;
                  mode_in = bld_pkg::MODE_IDLE;
                  if (dec > start_lvl) begin
                     act_in = bld_pkg::ACT_BAR;
                     mode_in = bld_pkg::MODE_BRAKING;
                     hold_in = '0;
                  end
               end
            endcase
            if ((mode_in == bld_pkg::MODE_BRAKING) && (dec > hold_lvl)) begin
               hold_in = '0;
            end
            if (mode_ff == bld_pkg::MODE_TIMEOUT) begin
               mode_in = bld_pkg::MODE_IDLE;
            end
         end
         bld_pkg::OP_C3: begin
            bar_in = (act_ff == bld_pkg::ACT_BAR) ? bar_r[BAR_W-1:0] : '0;
         end
         bld_pkg::OP_OUT: begin
            rsp_action_in = act_ff;
            rsp_bar_in = bar_ff;
            rsp_braking_in = (mode_ff == bld_pkg::MODE_BRAKING);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= bld_pkg::START_RST;
         hold_thr_ff <= bld_pkg::HOLD_RST;
         light_thr_ff <= bld_pkg::LIGHT_RST;
         timeout_ff <= bld_pkg::TIMEOUT_RST;
         short_ff <= '0;
         long_ff <= '0;
         mode_ff <= bld_pkg::MODE_IDLE;
         hold_ff <= '0;
      end else begin
         start_ff <= start_in;
         hold_thr_ff <= hold_thr_in;
         light_thr_ff <= light_thr_in;
         timeout_ff <= timeout_in;
         short_ff <= short_in;
         long_ff <= long_in;
         mode_ff <= mode_in;
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      accel_ff <= accel_in;
      light_ff <= light_in;
      num_ff <= num_in;
      prod_ff <= prod_in;
      act_ff <= act_in;
      bar_ff <= bar_in;
      rsp_action_ff <= rsp_action_in;
      rsp_bar_ff <= rsp_bar_in;
      rsp_braking_ff <= rsp_braking_in;
   end

   assign out_action = rsp_action_ff;
   assign out_bar = rsp_bar_ff;
   assign out_braking = rsp_braking_ff;

endmodule

`default_nettype wire

FILE: src/bld_ctrl.sv
// ----------------------------------------------------------------------------
// Brake light decider controller
// Sequences one item through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bld_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                req_tuser,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output bld_pkg::dp_cmd_type      cmd
);

   bld_pkg::ctl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bld_pkg::ST_WAIT: begin
            if (req_tvalid) begin
               state_in = req_tuser ? bld_pkg::ST_TICK : bld_pkg::ST_N1;
            end
         end
         bld_pkg::ST_TICK: state_in = bld_pkg::ST_OUT;
         bld_pkg::ST_N1:   state_in = bld_pkg::ST_MUL1;
         bld_pkg::ST_MUL1: state_in = bld_pkg::ST_C1;
         bld_pkg::ST_C1:   state_in = bld_pkg::ST_N2;
         bld_pkg::ST_N2:   state_in = bld_pkg::ST_MUL2;
         bld_pkg::ST_MUL2: state_in = bld_pkg::ST_C2;
         bld_pkg::ST_C2:   state_in = bld_pkg::ST_DEC;
         bld_pkg::ST_DEC:  state_in = bld_pkg::ST_MUL3;
         bld_pkg::ST_MUL3: state_in = bld_pkg::ST_C3;
         bld_pkg::ST_C3:   state_in = bld_pkg::ST_OUT;
         bld_pkg::ST_OUT: begin
            if (slot_free) begin
               state_in = bld_pkg::ST_WAIT;
            end
         end
         default: state_in = bld_pkg::ST_WAIT;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.load_in = 1'b0;
      cmd.op = bld_pkg::OP_NONE;
      case (state_ff)
         bld_pkg::ST_WAIT: begin
            req_tready = 1'b1;
            cmd.load_in = req_tvalid;
         end
         bld_pkg::ST_TICK: cmd.op = bld_pkg::OP_TICK;
         bld_pkg::ST_N1:   cmd.op = bld_pkg::OP_N1;
         bld_pkg::ST_MUL1: cmd.op = bld_pkg::OP_MUL1;
         bld_pkg::ST_C1:   cmd.op = bld_pkg::OP_C1;
         bld_pkg::ST_N2:   cmd.op = bld_pkg::OP_N2;
         bld_pkg::ST_MUL2: cmd.op = bld_pkg::OP_MUL2;
         bld_pkg::ST_C2:   cmd.op = bld_pkg::OP_C2;
         bld_pkg::ST_DEC:  cmd.op = bld_pkg::OP_DEC;
         bld_pkg::ST_MUL3: cmd.op = bld_pkg::OP_MUL3;
         bld_pkg::ST_C3:   cmd.op = bld_pkg::OP_C3;
         bld_pkg::ST_OUT:  cmd.op = slot_free ? bld_pkg::OP_OUT : bld_pkg::OP_NONE;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == bld_pkg::OP_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bld_pkg::ST_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: src/brake_light_decider_unit.sv
// ----------------------------------------------------------------------------
// Brake light decider unit
// Acceleration filtering and tail/brake light decisions for a bicycle lamp.
// ----------------------------------------------------------------------------
// One item at a time. A timer tick passes through ST_TICK and then ST_OUT,
// a sensor sample through ST_N1 to ST_C3 and then ST_OUT, where the result
// is registered. The sample path has the controller walking both averages
// and the bar index through one shared multiplier (three multiply passes,
// each with a register before and after). The next item is accepted at the
// first edge after its predecessor's result reaches the output register,
// while that result may still wait for rsp_tready. A later result holds in
// the controller until the earlier one is taken, and the input stays closed
// meanwhile. Exactly one result beat per accepted beat. Registers are
// written on csr_wen at index csr_addr; write only while no item is in work.
// ----------------------------------------------------------------------------
`default_nettype none

module brake_light_decider_unit #(
   parameter int LED_COUNT = bld_pkg::LED_COUNT_DEF,
   localparam int BAR_W = $clog2(LED_COUNT),
   localparam int RSP_W = ((3 + BAR_W + 7) / 8) * 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // accel_z[15:0], light_level[27:16], zero pad
   input  wire logic [bld_pkg::REQ_W-1:0]      req_tdata,
   // kind
   input  wire logic                           req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // led_action[1:0], bar_end[BAR_W+1:2], braking[BAR_W+2], zero pad
   output logic [RSP_W-1:0]                    rsp_tdata,
   input  wire logic                           csr_wen,
   input  wire logic [bld_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [bld_pkg::CSR_DATA_W-1:0] csr_wdata
);

   bld_pkg::dp_cmd_type cmd;
   logic [1:0]       out_action;
   logic [BAR_W-1:0] out_bar;
   logic             out_braking;

   bld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   bld_datapath #(
      .LED_COUNT (LED_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_data     (req_tdata[27:0]),
      .csr_wen     (csr_wen),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .out_action  (out_action),
      .out_bar     (out_bar),
      .out_braking (out_braking)
   );

   assign rsp_tdata = RSP_W'({out_braking, out_bar, out_action});

endmodule

`default_nettype wire

FILE: src/bld_chk.sv
// ----------------------------------------------------------------------------
// Brake light decider port checker
// Watches the top-level ports and is bound to the unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "brake_light_decider_unit_macros.svh"

module bld_chk #(
   parameter int LED_COUNT = bld_pkg::LED_COUNT_DEF,
   localparam int BAR_W = $clog2(LED_COUNT),
   localparam int RSP_W = ((3 + BAR_W + 7) / 8) * 8
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);

   logic bar_shown;
   logic braking_bit;

   assign bar_shown = (rsp_tdata[1:0] == bld_pkg::ACT_BAR);
   assign braking_bit = rsp_tdata[BAR_W+2];

   `BLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `BLD_ASSERT_IMPL(a_bar_braking, clock, reset, rsp_tvalid && bar_shown, braking_bit)
   `BLD_ASSERT_IMPL(a_bar_zero, clock, reset, rsp_tvalid && !bar_shown,
      rsp_tdata[BAR_W+1:2] == '0)
   `BLD_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind brake_light_decider_unit bld_chk #(
   .LED_COUNT (LED_COUNT)
) u_bld_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
